FILE: sv/srp_pkg.sv
// shared types, constants and register codes for the shelf rectangle packer
package srp_pkg;

    // defaults for the top level parameters
    localparam int DefMaxRects    = 64;
    localparam int DefMaxSizeLog2 = 12;

    // cursor and coordinate width inside the packer
    localparam int CurW = 13;

    // register reset values
    localparam logic [3:0] MarginReset = 4'd1;
    localparam logic [3:0] StartReset  = 4'd5;

    // register word indexes on the configuration port
    localparam logic RegMargin = 1'b0;
    localparam logic RegStart  = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_READ = 5'b00010,
        ST_STEP = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_BIG  = 5'b10000
    } state_t;

    // operands of one placement step
    typedef struct packed {
        logic [CurW-1:0] cur_x;
        logic [CurW-1:0] cur_y;
        logic [7:0]      w;
        logic [7:0]      h;
        logic [7:0]      tallest;
        logic [3:0]      margin;
        logic [3:0]      side_log2;
    } place_in_t;

    // outcome of one placement step
    typedef struct packed {
        logic            fit;
        logic [CurW-1:0] pos_x;
        logic [CurW-1:0] pos_y;
        logic [CurW-1:0] nxt_x;
        logic [CurW-1:0] nxt_y;
    } place_out_t;

endpackage

FILE: sv/shelf_rect_packer.sv
// shelf rectangle packer top level: load store, pack sequencer, result register
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | input     | in_valid / in_ready | rect_width, rect_height, last_rect
//  out     | output    | out_valid/out_ready | rect_index, pos_x, pos_y, size_log2,
//          |           |                     | too_large, last_result
//  cfg     | input     | apb psel/penable    | margin (0x0), start_size_log2 (0x4)
//
// in_ready is high only while loading, and a word is taken whenever in_valid is high.
// each pack attempt walks the store with a read and a step state per rectangle, and
// every doubling of the side restarts it; a final walk adds an emit state per
// rectangle to emit the results, where each result waits for out_ready.
// too large comes the cycle after the last word for a start size beyond the maximum,
// else right after the failed walk at the largest side; reset is async, active low.
module shelf_rect_packer #(
    parameter int MAX_RECTS     = srp_pkg::DefMaxRects,
    parameter int MAX_SIZE_LOG2 = srp_pkg::DefMaxSizeLog2
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rect_width,
    input  logic [7:0]  rect_height,
    input  logic        last_rect,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  rect_index,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic [3:0]  size_log2,
    output logic        too_large,
    output logic        last_result,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srp_pkg::*;

    localparam int IdxW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CntW = $clog2(MAX_RECTS + 1);
    localparam logic [3:0] MaxLog2 = 4'(MAX_SIZE_LOG2);

    state_t          st_reg, st_next;
    logic [3:0]      margin_reg, start_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic [7:0]      tallest_reg, tallest_next;
    logic [CurW-1:0] cur_x_reg, cur_x_next;
    logic [CurW-1:0] cur_y_reg, cur_y_next;
    logic [3:0]      side_reg, side_next;
    logic            emit_reg, emit_next;

    logic            ov_reg, ov_next;
    logic [5:0]      oidx_reg, oidx_next;
    logic [11:0]     ox_reg, ox_next;
    logic [11:0]     oy_reg, oy_next;
    logic [3:0]      osize_reg, osize_next;
    logic            obig_reg, obig_next;
    logic            olast_reg, olast_next;

    logic            cfg_wr;
    logic            in_acc;
    logic            out_acc;
    logic [3:0]      first_side;
    logic            ram_we;
    logic [15:0]     ram_rdata;
    logic [CntW-1:0] idx_inc;
    place_in_t       pin;
    place_out_t      pout;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MarginReset;
            start_reg  <= StartReset;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                RegMargin: margin_reg <= pwdata[3:0];
                RegStart:  start_reg  <= pwdata[3:0];
                default:   margin_reg <= margin_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            RegMargin: prdata = {28'd0, margin_reg};
            RegStart:  prdata = {28'd0, start_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // handshakes
    assign in_ready  = (st_reg == ST_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_acc   = ov_reg && out_ready;

    assign first_side = (start_reg == 4'd0) ? 4'd1 : start_reg;
    assign ram_we     = in_acc && (count_reg < CntW'(MAX_RECTS));
    assign idx_inc    = idx_reg + CntW'(1);

    // rectangle store, width in the low byte
    srp_ram #(
        .WIDTH (16),
        .DEPTH (MAX_RECTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IdxW-1:0]),
        .wdata ({rect_height, rect_width}),
        .raddr (idx_reg[IdxW-1:0]),
        .rdata (ram_rdata)
    );

    // placement unit operands
    assign pin.cur_x     = cur_x_reg;
    assign pin.cur_y     = cur_y_reg;
    assign pin.w         = ram_rdata[7:0];
    assign pin.h         = ram_rdata[15:8];
    assign pin.tallest   = tallest_reg;
    assign pin.margin    = margin_reg;
    assign pin.side_log2 = side_reg;

    srp_place_unit u_place (
        .pin  (pin),
        .pout (pout)
    );

    // pack sequencer
    always_comb
    begin
        st_next      = st_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        tallest_next = tallest_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        side_next    = side_reg;
        emit_next    = emit_reg;
        ov_next      = ov_reg;
        oidx_next    = oidx_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        osize_next   = osize_reg;
        obig_next    = obig_reg;
        olast_next   = olast_reg;

        unique case (st_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + CntW'(1);
                        if (rect_height > tallest_reg)
                        begin
                            tallest_next = rect_height;
                        end
                    end
                    if (last_rect)
                    begin
                        side_next  = first_side;
                        idx_next   = '0;
                        emit_next  = 1'b0;
                        cur_x_next = CurW'(margin_reg);
                        cur_y_next = CurW'(margin_reg);
                        if (first_side > MaxLog2)
                        begin
                            ov_next    = 1'b1;
                            oidx_next  = 6'd0;
                            ox_next    = 12'd0;
                            oy_next    = 12'd0;
                            osize_next = MaxLog2;
                            obig_next  = 1'b1;
                            olast_next = 1'b1;
                            st_next    = ST_BIG;
                        end
                        else
                        begin
                            st_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                st_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (!pout.fit)
                begin
                    // no room: double the side and restart, or give up
                    if (side_reg >= MaxLog2)
                    begin
                        ov_next    = 1'b1;
                        oidx_next  = 6'd0;
                        ox_next    = 12'd0;
                        oy_next    = 12'd0;
                        osize_next = MaxLog2;
                        obig_next  = 1'b1;
                        olast_next = 1'b1;
                        st_next    = ST_BIG;
                    end
                    else
                    begin
                        side_next  = side_reg + 4'd1;
                        idx_next   = '0;
                        cur_x_next = CurW'(margin_reg);
                        cur_y_next = CurW'(margin_reg);
                        st_next    = ST_READ;
                    end
                end
                else
                begin
                    cur_x_next = pout.nxt_x;
                    cur_y_next = pout.nxt_y;
                    if (emit_reg)
                    begin
                        ov_next    = 1'b1;
                        oidx_next  = 6'(idx_reg);
                        ox_next    = pout.pos_x[11:0];
                        oy_next    = pout.pos_y[11:0];
                        osize_next = side_reg;
                        obig_next  = 1'b0;
                        olast_next = (idx_inc == count_reg);
                        st_next    = ST_EMIT;
                    end
                    else if (idx_inc == count_reg)
                    begin
                        // pass fits: replay it to emit the positions
                        emit_next  = 1'b1;
                        idx_next   = '0;
                        cur_x_next = CurW'(margin_reg);
                        cur_y_next = CurW'(margin_reg);
                        st_next    = ST_READ;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        st_next  = ST_READ;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        count_next   = '0;
                        tallest_next = 8'd0;
                        cur_x_next   = '0;
                        cur_y_next   = '0;
                        side_next    = first_side;
                        emit_next    = 1'b0;
                        idx_next     = '0;
                        st_next      = ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        st_next  = ST_READ;
                    end
                end
            end
            ST_BIG:
            begin
                if (out_acc)
                begin
                    ov_next      = 1'b0;
                    count_next   = '0;
                    tallest_next = 8'd0;
                    cur_x_next   = '0;
                    cur_y_next   = '0;
                    side_next    = first_side;
                    emit_next    = 1'b0;
                    idx_next     = '0;
                    st_next      = ST_LOAD;
                end
            end
            default:
            begin
                st_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_LOAD;
            count_reg   <= '0;
            idx_reg     <= '0;
            tallest_reg <= 8'd0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            side_reg    <= StartReset;
            emit_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            tallest_reg <= tallest_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            side_reg    <= side_next;
            emit_reg    <= emit_next;
            ov_reg      <= ov_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        oidx_reg  <= oidx_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        osize_reg <= osize_next;
        obig_reg  <= obig_next;
        olast_reg <= olast_next;
    end

    assign rect_index  = oidx_reg;
    assign pos_x       = ox_reg;
    assign pos_y       = oy_reg;
    assign size_log2   = osize_reg;
    assign too_large   = obig_reg;
    assign last_result = olast_reg;

    // a pending result belongs to a result state
    a_ov_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (st_reg == ST_EMIT || st_reg == ST_BIG))
        else $error("result valid outside a result state");

    // loading and delivering never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // a too large result ends the run
    a_big_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_large) |-> last_result)
        else $error("too large result not marked last");

    // store fill never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(MAX_RECTS))
        else $error("rectangle count beyond capacity");

    // a delivered final result returns the block to loading
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last_result) |=> (in_ready && count_reg == '0))
        else $error("run not cleared after final result");

endmodule

FILE: sv/srp_ram.sv
// generic single write port ram with registered read
module srp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/srp_place_unit.sv
// shared placement unit: one shelf placement decision per use
module srp_place_unit (
    input  srp_pkg::place_in_t  pin,
    output srp_pkg::place_out_t pout
);
    import srp_pkg::*;

    logic [CurW:0]   side;
    logic [CurW:0]   sum_x;
    logic [CurW:0]   sum_y;
    logic [4:0]      m2;
    logic [CurW-1:0] row_y;
    logic            zero;

    // shared adders and compares against the side length
    assign side  = (CurW+1)'(1) << pin.side_log2;
    assign m2    = {pin.margin, 1'b0};
    assign sum_x = (CurW+1)'(pin.cur_x) + (CurW+1)'(pin.w) + (CurW+1)'(m2);
    assign sum_y = (CurW+1)'(pin.cur_y) + (CurW+1)'(pin.tallest) + (CurW+1)'(m2);
    assign row_y = pin.cur_y + CurW'(pin.tallest) + CurW'(pin.margin);
    assign zero  = (pin.w == 8'd0) || (pin.h == 8'd0);

    // pick current row, new row or no fit; a zero-size rectangle takes the cursor without moving it
    always_comb
    begin
        pout.fit   = 1'b1;
        pout.pos_x = pin.cur_x;
        pout.pos_y = pin.cur_y;
        pout.nxt_x = pin.cur_x;
        pout.nxt_y = pin.cur_y;
        if (zero)
        begin
            pout.fit = 1'b1;
        end
        else if (sum_x < side)
        begin
            pout.nxt_x = pin.cur_x + CurW'(pin.w) + CurW'(pin.margin);
        end
        else if (sum_y < side)
        begin
            pout.pos_x = CurW'(pin.margin);
            pout.pos_y = row_y;
            pout.nxt_x = CurW'(pin.w) + CurW'(m2);
            pout.nxt_y = row_y;
        end
        else
        begin
            pout.fit = 1'b0;
        end
    end

endmodule

FILE: test/shelf_rect_packer_tb.sv
// self-checking testbench for the shelf rectangle packer
module shelf_rect_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srp_pkg::*;

    localparam int HalfPeriod   = 10;
    localparam int ResetCycles  = 9;
    localparam int RandomItems  = 410;
    localparam int DrainGap     = 24;
    localparam int EndGap       = 40;
    localparam int HoldCycles   = 400;
    localparam int QuietLimit   = 12000;
    localparam int MaxReports   = 40;

    // one expected result word
    typedef struct packed {
        logic [5:0]  idx;
        logic [11:0] x;
        logic [11:0] y;
        logic [3:0]  side_lg;
        logic        big;
        logic        fin;
    } placement_t;

    // directed plan rows
    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic       reg_sel;
        logic [3:0] cfg_val;
        logic [7:0] w;
        logic [7:0] h;
        logic       fin;
        logic       lit;
        placement_t want;
    } stim_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  rect_width  = '0;
    logic [7:0]  rect_height = '0;
    logic        last_rect   = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [5:0]  rect_index;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [3:0]  size_log2;
    logic        too_large;
    logic        last_result;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    shelf_rect_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .last_rect   (last_rect),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rect_index  (rect_index),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .size_log2   (size_log2),
        .too_large   (too_large),
        .last_result (last_result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // packer state as the testbench sees it
    logic [3:0]  margin_cfg = MarginReset;
    logic [3:0]  start_cfg  = StartReset;
    logic [7:0]  held_w [DefMaxRects];
    logic [7:0]  held_h [DefMaxRects];
    int          held_count = 0;
    logic [7:0]  row_height = '0;

    placement_t  placements_due [$];
    placement_t  literal_word;
    bit          literal_armed = 1'b0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    stim_row_t   plan [$];

    always #(HalfPeriod) clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MaxReports)
            $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    endtask

    // store one word; on the last word pack the set and queue its placements
    function automatic void shelf_place(input logic [7:0] w, input logic [7:0] h,
                                        input logic fin, input bit publish);
        int side_lg;
        int side;
        int cx;
        int cy;
        int m;
        int i;
        bit ok;
        bit fits;
        int px [DefMaxRects];
        int py [DefMaxRects];
        placement_t p;
        if (held_count < DefMaxRects) begin
            held_w[held_count] = w;
            held_h[held_count] = h;
            held_count++;
            if (h > row_height)
                row_height = h;
        end
        if (!fin)
            return;
        m = margin_cfg;
        side_lg = (start_cfg == 4'd0) ? 1 : start_cfg;
        fits = 1'b0;
        // try sides upward until every rectangle lands
        while (!fits && side_lg <= DefMaxSizeLog2) begin
            side = 1 << side_lg;
            cx = m;
            cy = m;
            ok = 1'b1;
            for (i = 0; i < held_count && ok; i++) begin
                if (held_w[i] == 8'd0 || held_h[i] == 8'd0) begin
                    px[i] = cx;
                    py[i] = cy;
                end else if (cx + held_w[i] + 2 * m < side) begin
                    px[i] = cx;
                    py[i] = cy;
                    cx = cx + held_w[i] + m;
                end else if (cy + row_height + 2 * m < side) begin
                    cy = cy + row_height + m;
                    px[i] = m;
                    py[i] = cy;
                    cx = held_w[i] + 2 * m;
                end else begin
                    ok = 1'b0;
                end
            end
            if (ok)
                fits = 1'b1;
            else
                side_lg++;
        end
        if (publish) begin
            if (!fits) begin
                p = '0;
                p.side_lg = 4'(DefMaxSizeLog2);
                p.big = 1'b1;
                p.fin = 1'b1;
                placements_due.push_back(p);
            end else begin
                for (i = 0; i < held_count; i++) begin
                    p.idx = 6'(i);
                    p.x = 12'(px[i]);
                    p.y = 12'(py[i]);
                    p.side_lg = 4'(side_lg);
                    p.big = 1'b0;
                    p.fin = (i == held_count - 1);
                    placements_due.push_back(p);
                end
            end
        end
        held_count = 0;
        row_height = '0;
    endfunction

    // result check first, then prediction of the word taken at this edge
    always @(posedge clk) begin
        placement_t got;
        placement_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = {rect_index, pos_x, pos_y, size_log2, too_large, last_result};
                if (placements_due.size() == 0) begin
                    report_mismatch("unexpected result, rect_index", got.idx, -1);
                end else begin
                    want = placements_due.pop_front();
                    if (got.idx != want.idx)
                        report_mismatch("rect_index", got.idx, want.idx);
                    if (got.x != want.x)
                        report_mismatch("pos_x", got.x, want.x);
                    if (got.y != want.y)
                        report_mismatch("pos_y", got.y, want.y);
                    if (got.side_lg != want.side_lg)
                        report_mismatch("size_log2", got.side_lg, want.side_lg);
                    if (got.big != want.big)
                        report_mismatch("too_large", got.big, want.big);
                    if (got.fin != want.fin)
                        report_mismatch("last_result", got.fin, want.fin);
                end
                results_seen++;
            end
            if (in_valid && in_ready) begin
                shelf_place(rect_width, rect_height, last_rect, !(literal_armed && last_rect));
                if (literal_armed && last_rect) begin
                    placements_due.push_back(literal_word);
                    literal_armed = 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one input word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] w, input logic [7:0] h, input logic fin);
        int gap;
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rect_width  <= w;
        rect_height <= h;
        last_rect   <= fin;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending and wait until every queued placement has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (DrainGap) @(posedge clk);
    endtask

    // apb write followed by a read-back of the same register
    task automatic write_register(input logic sel, input logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {28'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (sel == RegMargin)
            margin_cfg = val;
        else
            start_cfg = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[3:0] != val)
            report_mismatch("register read-back", prdata[3:0], val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic shuffle_config();
        int r;
        r = $urandom_range(99);
        write_register(RegMargin, (r < 15) ? 4'd0 : (r < 30) ? 4'd15 : 4'($urandom_range(15)));
        r = $urandom_range(99);
        write_register(RegStart, (r < 75) ? 4'($urandom_range(1, 9)) : 4'($urandom_range(15)));
    endtask

    // one complete rectangle set of n words
    task automatic send_set(input int n, input int style);
        logic [7:0] w;
        logic [7:0] h;
        for (int k = 0; k < n; k++) begin
            case (style)
                0: begin
                    w = 8'($urandom_range(1, 30));
                    h = 8'($urandom_range(1, 30));
                end
                1: begin
                    w = 8'($urandom_range(255));
                    h = 8'($urandom_range(255));
                end
                default: begin
                    w = 8'($urandom_range(1, 255));
                    h = 8'($urandom_range(1, 12));
                end
            endcase
            if ($urandom_range(99) < 8)
                w = 8'd0;
            if ($urandom_range(99) < 8)
                h = 8'd0;
            send_word(w, h, k == n - 1);
        end
    endtask

    // plan row builders
    function automatic stim_row_t mk_item(input logic [7:0] w, input logic [7:0] h,
                                          input logic fin);
        stim_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.w = w;
        row.h = h;
        row.fin = fin;
        return row;
    endfunction

    function automatic stim_row_t mk_placed(input logic [7:0] w, input logic [7:0] h,
                                            input logic [11:0] x, input logic [11:0] y,
                                            input logic [3:0] side_lg);
        stim_row_t row;
        row = mk_item(w, h, 1'b1);
        row.lit = 1'b1;
        row.want.x = x;
        row.want.y = y;
        row.want.side_lg = side_lg;
        row.want.fin = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t mk_big(input logic [7:0] w, input logic [7:0] h);
        stim_row_t row;
        row = mk_item(w, h, 1'b1);
        row.lit = 1'b1;
        row.want.side_lg = 4'(DefMaxSizeLog2);
        row.want.big = 1'b1;
        row.want.fin = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t mk_cfg(input logic sel, input logic [3:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_sel = sel;
        row.cfg_val = val;
        return row;
    endfunction

    initial begin
        int phase;
        int next_phase;
        int random_stored;
        int sets_since_cfg;
        int n;
        int r;
        bit overflow_done;
        bit full_done;

        // single rectangles at reset settings, extremes and degenerate sizes
        plan.push_back(mk_placed(8'd1, 8'd1, 12'd1, 12'd1, 4'd5));
        plan.push_back(mk_placed(8'd0, 8'd0, 12'd1, 12'd1, 4'd5));
        plan.push_back(mk_placed(8'd255, 8'd255, 12'd1, 12'd1, 4'd9));
        plan.push_back(mk_placed(8'd255, 8'd0, 12'd1, 12'd1, 4'd5));
        plan.push_back(mk_placed(8'd0, 8'd255, 12'd1, 12'd1, 4'd5));
        // row wrap within one set
        plan.push_back(mk_item(8'd10, 8'd5, 1'b0));
        plan.push_back(mk_item(8'd10, 8'd7, 1'b0));
        plan.push_back(mk_item(8'd10, 8'd3, 1'b0));
        plan.push_back(mk_item(8'd10, 8'd4, 1'b1));
        // margin extremes
        plan.push_back(mk_cfg(RegMargin, 4'd0));
        plan.push_back(mk_placed(8'd255, 8'd255, 12'd0, 12'd0, 4'd8));
        plan.push_back(mk_cfg(RegMargin, 4'd15));
        plan.push_back(mk_placed(8'd1, 8'd1, 12'd15, 12'd15, 4'd6));
        // start size of zero runs as one
        plan.push_back(mk_cfg(RegStart, 4'd0));
        plan.push_back(mk_placed(8'd0, 8'd0, 12'd15, 12'd15, 4'd1));
        plan.push_back(mk_item(8'd3, 8'd4, 1'b0));
        plan.push_back(mk_item(8'd5, 8'd2, 1'b0));
        plan.push_back(mk_item(8'd7, 8'd9, 1'b1));
        // start size beyond the maximum gives too large at once
        plan.push_back(mk_cfg(RegStart, 4'd13));
        plan.push_back(mk_big(8'd9, 8'd9));
        plan.push_back(mk_cfg(RegStart, 4'd15));
        plan.push_back(mk_item(8'd0, 8'd0, 1'b0));
        plan.push_back(mk_big(8'd4, 8'd4));
        // largest legal start, then smallest with repeated doubling
        plan.push_back(mk_cfg(RegStart, 4'd12));
        plan.push_back(mk_cfg(RegMargin, 4'd0));
        plan.push_back(mk_item(8'd2, 8'd2, 1'b0));
        plan.push_back(mk_item(8'd3, 8'd3, 1'b1));
        plan.push_back(mk_cfg(RegMargin, 4'd1));
        plan.push_back(mk_cfg(RegStart, 4'd1));
        plan.push_back(mk_item(8'd8, 8'd8, 1'b0));
        plan.push_back(mk_item(8'd8, 8'd8, 1'b0));
        plan.push_back(mk_item(8'd8, 8'd8, 1'b1));

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_drained();
                write_register(plan[i].reg_sel, plan[i].cfg_val);
            end else begin
                // armed after this edge, so the word taken at this edge keeps its own
                if (plan[i].lit) begin
                    literal_word <= plan[i].want;
                    literal_armed <= 1'b1;
                end
                send_word(plan[i].w, plan[i].h, plan[i].fin);
            end
        end

        // random sets over four idling phases
        phase = -1;
        random_stored = 0;
        sets_since_cfg = 0;
        overflow_done = 1'b0;
        full_done = 1'b0;
        while (random_stored < RandomItems) begin
            next_phase = random_stored * 4 / RandomItems;
            if (next_phase != phase) begin
                phase = next_phase;
                wait_drained();
                case (phase)
                    0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                    1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
                    2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
                    default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
                endcase
                shuffle_config();
                sets_since_cfg = 0;
                // long receiver hold-off while sets keep coming
                if (phase == 2)
                    hold_seq++;
            end else if (sets_since_cfg >= 4) begin
                wait_drained();
                shuffle_config();
                sets_since_cfg = 0;
            end
            r = $urandom_range(99);
            if (phase == 1 && !overflow_done) begin
                n = $urandom_range(65, 70);
                overflow_done = 1'b1;
            end else if (phase == 3 && !full_done) begin
                n = DefMaxRects;
                full_done = 1'b1;
            end else if (r < 4) begin
                n = $urandom_range(65, 68);
            end else if (r < 14) begin
                n = $urandom_range(13, 40);
            end else begin
                n = $urandom_range(1, 12);
            end
            send_set(n, $urandom_range(2));
            random_stored += (n > DefMaxRects) ? DefMaxRects : n;
            sets_since_cfg++;
        end

        wait_drained();
        repeat (EndGap) @(posedge clk);
        if (placements_due.size() != 0)
            report_mismatch("results never delivered", 0, placements_due.size());
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
